// File: rtl/pulsing_inverse_square_attractor_macros.svh
// Assertion macros for the pulsing inverse-square attractor block.
`ifndef PULSING_INVERSE_SQUARE_ATTRACTOR_MACROS_SVH
`define PULSING_INVERSE_SQUARE_ATTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
`define PISA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PISA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PISA_ASSERT_IMP(lbl, ante, cons, msg)
`define PISA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/pisa_pkg.sv
// Types, constants and the sine table entry function of the attractor block.
package pisa_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_SOURCE_X         = 3'd0;
  localparam logic [2:0] CFG_SOURCE_Y         = 3'd1;
  localparam logic [2:0] CFG_SOURCE_Z         = 3'd2;
  localparam logic [2:0] CFG_GRAVITY_STRENGTH = 3'd3;
  localparam logic [2:0] CFG_SOURCE_MASS      = 3'd4;

  // phase step in turns per millisecond, 2^48 / (2000 pi)
  localparam logic [35:0] PHASE_K     = 36'd44798133900;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'h4000_0000;

  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 34;

  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0]       neg;
    logic             gneg;
    logic [5:0]       sh;
    logic             coinc;
    logic             active;
  } side_t;

  typedef struct packed {
    logic [32:0]      rem;
    logic [30:0]      root;
    logic [61:0]      r2;
    logic [62:0]      gm;
    logic [2:0][29:0] d;
    side_t            side;
  } sq_t;

  typedef struct packed {
    logic [33:0]      irem;
    logic [33:0]      iq;
    logic [33:0]      vd;
    logic [2:0][30:0] urem;
    logic [2:0][3:0]  unum;
    logic [2:0][33:0] uq;
    logic [30:0]      root;
    logic [62:0]      gm;
    side_t            side;
  } dv_t;

  typedef struct packed {
    logic [63:0]      pp00;
    logic [33:0]      pp01;
    logic [62:0]      pp10;
    logic [32:0]      pp11;
    logic [2:0][30:0] u;
    side_t            side;
  } xa_t;

  typedef struct packed {
    logic [96:0]      x;
    logic [2:0][30:0] u;
    side_t            side;
  } xb_t;

  typedef struct packed {
    logic [2:0][63:0] c0;
    logic [2:0][63:0] c1;
    logic [2:0][63:0] c2;
    side_t            side;
  } xc_t;

  typedef struct packed {
    logic [2:0][127:0] p;
    side_t             side;
  } xd_t;

  typedef struct packed {
    logic [2:0][41:0] tc;
    side_t            side;
  } xe_t;

  typedef struct packed {
    logic [2:0][31:0] vel;
    logic             coinc;
    logic             sat;
  } res_t;

  // Quarter-wave sine magnitude in Q1.15, odd series to x^11 in Q2.30
  function automatic logic [14:0] sine_mag(input int unsigned a, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    x  = (64'(a) * HALF_PI_Q30) >> (bits - 2);
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    v  = (((x * t) >> 30) + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return v[14:0];
  endfunction

endpackage

// File: rtl/pulsing_inverse_square_attractor.sv
// Pulsing inverse-square attractor: velocity update pipeline for one particle a cycle while the skid is empty.
// Throughput: one transaction per cycle while the output is not stalled; the length is set by the square root
// (31 stages, one root bit each) and the shared divide chain (34 stages, one quotient bit each).
// A two-entry output (final register plus skid) lets the pipeline keep advancing as back-pressure first appears.
// Reset clears the valid bits, the skid valid flag and all configuration registers to zero.
`include "pulsing_inverse_square_attractor_macros.svh"

module pulsing_inverse_square_attractor #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [30:0] particle_mass_i,
  input  logic [31:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_vel_x_o,
  output logic [31:0] new_vel_y_o,
  output logic [31:0] new_vel_z_o,
  output logic        coincident_o,
  output logic        saturated_o
);

  localparam int B       = SINE_TABLE_BITS;
  localparam int A_W     = B - 1;
  localparam int QUARTER = 1 << (B - 2);
  localparam int SQ_N    = pisa_pkg::SQ_STEPS;
  localparam int DV_N    = pisa_pkg::DIV_STEPS;
  localparam int V_SQ0   = 6;
  localparam int V_DV0   = V_SQ0 + SQ_N;
  localparam int V_XA    = V_DV0 + DV_N;
  localparam int VN      = V_XA + 6;
  localparam int V_OUT   = VN - 1;

  typedef logic [14:0] lut_t [QUARTER+1];

  function automatic lut_t build_lut();
    lut_t tb;
    for (int k = 0; k <= QUARTER; k++) tb[k] = pisa_pkg::sine_mag(k, B);
    return tb;
  endfunction

  localparam lut_t SINE_LUT = build_lut();

  // configuration registers
  logic [2:0][31:0] src_q;
  logic [31:0]      strength_q;
  logic [30:0]      smass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q      <= '0;
      strength_q <= '0;
      smass_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pisa_pkg::CFG_SOURCE_X:         src_q[0]   <= cfg_wdata_i;
        pisa_pkg::CFG_SOURCE_Y:         src_q[1]   <= cfg_wdata_i;
        pisa_pkg::CFG_SOURCE_Z:         src_q[2]   <= cfg_wdata_i;
        pisa_pkg::CFG_GRAVITY_STRENGTH: strength_q <= cfg_wdata_i;
        pisa_pkg::CFG_SOURCE_MASS:      smass_q    <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid line
  logic          en;
  logic [VN-1:0] vld_q;
  logic          skid_v_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[VN-2:0], in_valid_i};
  end

  // stage 1: offsets from the source, phase products
  logic [2:0][31:0] pos;
  logic [2:0][31:0] vin;
  logic [2:0][32:0] dd;
  logic [2:0][31:0] mg1;
  pisa_pkg::side_t  sd1;
  pisa_pkg::side_t  s1_side_q;
  logic [2:0][31:0] s1_mag_q;
  logic [47:0]      s1_plo_q;
  logic [23:0]      s1_phi_q;

  assign pos = {pos_z_i, pos_y_i, pos_x_i};
  assign vin = {vel_z_i, vel_y_i, vel_x_i};

  always_comb begin
    sd1        = '0;
    sd1.vel    = vin;
    sd1.active = (particle_mass_i != '0);
    for (int i = 0; i < 3; i++) begin
      dd[i]      = {pos[i][31], pos[i]} - {src_q[i][31], src_q[i]};
      sd1.neg[i] = dd[i][32];
      mg1[i]     = dd[i][32] ? 32'(-dd[i]) : dd[i][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q <= sd1;
      s1_mag_q  <= mg1;
      s1_plo_q  <= 48'(56'(time_ms_i) * 56'(pisa_pkg::PHASE_K[23:0]));
      s1_phi_q  <= 24'(44'(time_ms_i) * 44'(pisa_pkg::PHASE_K[35:24]));
    end
  end

  // stage 2: table index, largest offset, coincidence
  logic [47:0]      frac;
  logic [B:0]       idx_p;
  logic [31:0]      emax;
  pisa_pkg::side_t  sd2;
  logic [B-1:0]     s2_idx_q;
  logic [31:0]      s2_emax_q;
  logic [2:0][31:0] s2_mag_q;
  pisa_pkg::side_t  s2_side_q;

  always_comb begin
    frac  = s1_plo_q + {s1_phi_q, 24'd0};
    idx_p = frac[47 -: B+1] + (B+1)'(1);
    emax  = s1_mag_q[0];
    if (s1_mag_q[1] > emax) emax = s1_mag_q[1];
    if (s1_mag_q[2] > emax) emax = s1_mag_q[2];
    sd2        = s1_side_q;
    sd2.coinc  = (emax == '0);
    sd2.active = s1_side_q.active && (emax != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_idx_q  <= idx_p[B:1];
      s2_emax_q <= emax;
      s2_mag_q  <= s1_mag_q;
      s2_side_q <= sd2;
    end
  end

  // stage 3: sine lookup, normalising shift
  logic [1:0]         quad;
  logic [A_W-1:0]     tab_a;
  logic [14:0]        smag;
  logic signed [15:0] sine;
  logic [5:0]         bl;
  pisa_pkg::side_t    sd3;
  logic signed [15:0] s3_sine_q;
  logic [2:0][31:0]   s3_mag_q;
  pisa_pkg::side_t    s3_side_q;

  always_comb begin
    quad  = s2_idx_q[B-1:B-2];
    tab_a = quad[0] ? (A_W'(QUARTER) - {1'b0, s2_idx_q[B-3:0]}) : {1'b0, s2_idx_q[B-3:0]};
    smag  = SINE_LUT[tab_a];
    sine  = quad[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
    bl    = '0;
    for (int k = 0; k < 32; k++) begin
      if (s2_emax_q[k]) bl = 6'(k + 1);
    end
    sd3    = s2_side_q;
    sd3.sh = bl - 6'd30;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sine_q <= sine;
      s3_mag_q  <= s2_mag_q;
      s3_side_q <= sd3;
    end
  end

  // stage 4: gravity product, normalised offsets
  logic signed [47:0] prod;
  logic [4:0]         lsh;
  logic [2:0][29:0]   dn;
  logic signed [47:0] s4_prod_q;
  logic [2:0][29:0]   s4_d_q;
  pisa_pkg::side_t    s4_side_q;

  always_comb begin
    prod = 48'(signed'(strength_q)) * 48'(s3_sine_q);
    lsh  = 5'(-s3_side_q.sh);
    for (int i = 0; i < 3; i++) begin
      dn[i] = s3_side_q.sh[5] ? 30'(s3_mag_q[i] << lsh) : 30'(s3_mag_q[i] >> s3_side_q.sh[1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_prod_q <= prod;
      s4_d_q    <= dn;
      s4_side_q <= s3_side_q;
    end
  end

  // stage 5: gravity magnitude, squares
  logic [47:0]      pmag;
  pisa_pkg::side_t  sd5;
  logic [31:0]      s5_gmag_q;
  logic [2:0][59:0] s5_sq_q;
  logic [2:0][29:0] s5_d_q;
  pisa_pkg::side_t  s5_side_q;

  always_comb begin
    pmag     = s4_prod_q[47] ? 48'(-s4_prod_q) : s4_prod_q;
    sd5      = s4_side_q;
    sd5.gneg = s4_prod_q[47];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_gmag_q <= 32'((pmag + 48'd16384) >> 15);
      for (int i = 0; i < 3; i++) s5_sq_q[i] <= 60'(s4_d_q[i]) * 60'(s4_d_q[i]);
      s5_d_q    <= s4_d_q;
      s5_side_q <= sd5;
    end
  end

  // stage 6: gravity times source mass, squared radius
  pisa_pkg::sq_t s6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q.rem  <= '0;
      s6_q.root <= '0;
      s6_q.gm   <= 63'(s5_gmag_q) * 63'(smass_q);
      s6_q.r2   <= 62'(s5_sq_q[0]) + 62'(s5_sq_q[1]) + 62'(s5_sq_q[2]);
      s6_q.d    <= s5_d_q;
      s6_q.side <= s5_side_q;
    end
  end

  // square root, one root bit a stage
  pisa_pkg::sq_t sq_q [SQ_N];

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam int K = SQ_N - 1 - j;
    pisa_pkg::sq_t sq_src;
    pisa_pkg::sq_t sq_nxt;
    logic [34:0]   rs;
    logic [32:0]   trial;

    if (j == 0) begin : g_first
      assign sq_src = s6_q;
    end else begin : g_next
      assign sq_src = sq_q[j-1];
    end

    always_comb begin
      sq_nxt = sq_src;
      rs     = {sq_src.rem, sq_src.r2[2*K+1 -: 2]};
      trial  = {sq_src.root, 2'b01};
      if (rs >= {2'b00, trial}) begin
        sq_nxt.rem  = 33'(rs - {2'b00, trial});
        sq_nxt.root = {sq_src.root[29:0], 1'b1};
      end else begin
        sq_nxt.rem  = rs[32:0];
        sq_nxt.root = {sq_src.root[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) sq_q[j] <= sq_nxt;
    end
  end

  // set up the inverse and the unit vector divides
  pisa_pkg::dv_t dv_init;
  pisa_pkg::sq_t sq_end;

  assign sq_end = sq_q[SQ_N-1];

  always_comb begin
    dv_init      = '0;
    dv_init.irem = 34'h2000_0000;
    dv_init.vd   = sq_end.r2[61:28];
    dv_init.root = sq_end.root;
    dv_init.gm   = sq_end.gm;
    dv_init.side = sq_end.side;
    for (int i = 0; i < 3; i++) begin
      dv_init.urem[i] = 31'(sq_end.d[i] >> 4);
      dv_init.unum[i] = sq_end.d[i][3:0];
    end
  end

  // restoring divides, one quotient bit a stage
  pisa_pkg::dv_t dv_q [DV_N];

  for (genvar j = 0; j < DV_N; j++) begin : g_div
    pisa_pkg::dv_t dv_src;
    pisa_pkg::dv_t dv_nxt;
    logic [34:0]   irs;
    logic [31:0]   urs;

    if (j == 0) begin : g_first
      assign dv_src = dv_init;
    end else begin : g_next
      assign dv_src = dv_q[j-1];
    end

    always_comb begin
      dv_nxt = dv_src;
      urs    = '0;
      irs    = {dv_src.irem, 1'b0};
      if (irs >= {1'b0, dv_src.vd}) begin
        dv_nxt.irem = 34'(irs - {1'b0, dv_src.vd});
        dv_nxt.iq   = {dv_src.iq[32:0], 1'b1};
      end else begin
        dv_nxt.irem = irs[33:0];
        dv_nxt.iq   = {dv_src.iq[32:0], 1'b0};
      end
      for (int i = 0; i < 3; i++) begin
        urs            = {dv_src.urem[i], dv_src.unum[i][3]};
        dv_nxt.unum[i] = {dv_src.unum[i][2:0], 1'b0};
        if (urs >= {1'b0, dv_src.root}) begin
          dv_nxt.urem[i] = 31'(urs - {1'b0, dv_src.root});
          dv_nxt.uq[i]   = {dv_src.uq[i][32:0], 1'b1};
        end else begin
          dv_nxt.urem[i] = urs[30:0];
          dv_nxt.uq[i]   = {dv_src.uq[i][32:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) dv_q[j] <= dv_nxt;
    end
  end

  // scale partial products of gravity-mass times inverse
  pisa_pkg::dv_t dv_end;
  pisa_pkg::xa_t xa_q;
  pisa_pkg::xb_t xb_q;
  pisa_pkg::xc_t xc_q;
  pisa_pkg::xd_t xd_q;
  pisa_pkg::xe_t xe_q;

  assign dv_end = dv_q[DV_N-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q.pp00 <= 64'(dv_end.gm[31:0]) * 64'(dv_end.iq[31:0]);
      xa_q.pp01 <= 34'(dv_end.gm[31:0]) * 34'(dv_end.iq[33:32]);
      xa_q.pp10 <= 63'(dv_end.gm[62:32]) * 63'(dv_end.iq[31:0]);
      xa_q.pp11 <= 33'(dv_end.gm[62:32]) * 33'(dv_end.iq[33:32]);
      for (int i = 0; i < 3; i++) xa_q.u[i] <= dv_end.uq[i][30:0];
      xa_q.side <= dv_end.side;
    end
  end

  // sum the scale
  always_ff @(posedge clk_i) begin
    if (en) begin
      xb_q.x    <= 97'(xa_q.pp00) + {31'd0, xa_q.pp01, 32'd0} + {2'd0, xa_q.pp10, 32'd0}
                 + {xa_q.pp11, 64'd0};
      xb_q.u    <= xa_q.u;
      xb_q.side <= xa_q.side;
    end
  end

  // partial products of scale times unit vector
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        xc_q.c0[i] <= 64'(xb_q.x[31:0]) * 64'(xb_q.u[i]);
        xc_q.c1[i] <= 64'(xb_q.x[63:32]) * 64'(xb_q.u[i]);
        xc_q.c2[i] <= 64'(xb_q.x[96:64]) * 64'(xb_q.u[i]);
      end
      xc_q.side <= xb_q.side;
    end
  end

  // sum the full products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        xd_q.p[i] <= 128'(xc_q.c0[i]) + {32'd0, xc_q.c1[i], 32'd0} + {xc_q.c2[i], 64'd0};
      end
      xd_q.side <= xc_q.side;
    end
  end

  // shift down to one bit above the rounding point, clip early
  logic [7:0]       shamt;
  logic [2:0][127:0] tsh;

  always_comb begin
    shamt = 8'd104 + {xd_q.side.sh[5], xd_q.side.sh, 1'b0};
    for (int i = 0; i < 3; i++) tsh[i] = xd_q.p[i] >> shamt[6:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        xe_q.tc[i] <= (tsh[i][127:42] != '0) ? 42'h200_0000_0000 : tsh[i][41:0];
      end
      xe_q.side <= xd_q.side;
    end
  end

  // round, cap, apply and saturate
  logic [2:0][42:0]        dvr;
  logic [2:0][40:0]        dvc;
  logic signed [42:0]      nv [3];
  pisa_pkg::res_t          res;
  pisa_pkg::res_t          out_q;
  pisa_pkg::res_t          skid_q;
  pisa_pkg::res_t          shown;

  always_comb begin
    res       = '0;
    res.coinc = xe_q.side.coinc;
    for (int i = 0; i < 3; i++) begin
      dvr[i] = (43'(xe_q.tc[i]) + 43'd1) >> 1;
      dvc[i] = (dvr[i] > 43'h100_0000_0000) ? 41'h100_0000_0000 : dvr[i][40:0];
      if (xe_q.side.neg[i] != xe_q.side.gneg) begin
        nv[i] = 43'(signed'(xe_q.side.vel[i])) + signed'({2'b00, dvc[i]});
      end else begin
        nv[i] = 43'(signed'(xe_q.side.vel[i])) - signed'({2'b00, dvc[i]});
      end
      res.vel[i] = xe_q.side.vel[i];
      if (xe_q.side.active) begin
        if (nv[i] > 43'sd2147483647) begin
          res.vel[i] = 32'h7fff_ffff;
          res.sat    = 1'b1;
        end else if (nv[i] < -43'sd2147483648) begin
          res.vel[i] = 32'h8000_0000;
          res.sat    = 1'b1;
        end else begin
          res.vel[i] = nv[i][31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= res;
  end

  // hold a stalled result in the skid so the pipeline need not stop at once when the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_ready_i) skid_v_q <= 1'b0;
    end else if (vld_q[V_OUT] && !out_ready_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) skid_q <= out_q;
  end

  assign shown        = skid_v_q ? skid_q : out_q;
  assign out_valid_o  = skid_v_q || vld_q[V_OUT];
  assign new_vel_x_o  = shown.vel[0];
  assign new_vel_y_o  = shown.vel[1];
  assign new_vel_z_o  = shown.vel[2];
  assign coincident_o = shown.coinc;
  assign saturated_o  = shown.sat;

  `PISA_ASSERT_NXT(a_skid_hold, skid_v_q && !out_ready_i, skid_v_q && $stable(skid_q), "skid lost a stalled result")
  `PISA_ASSERT_IMP(a_coinc_nosat, out_valid_o && coincident_o, !saturated_o, "coincident result flagged as saturated")
  `PISA_ASSERT_IMP(a_sqrt_floor, vld_q[V_DV0-1] && sq_end.side.active, (64'(sq_end.root) * 64'(sq_end.root)) <= 64'(sq_end.r2), "square root above its operand")
  `PISA_ASSERT_IMP(a_unit_bound, vld_q[V_XA-1] && dv_end.side.active, dv_end.uq[0] <= 34'h4000_0000 && dv_end.uq[1] <= 34'h4000_0000 && dv_end.uq[2] <= 34'h4000_0000, "unit vector component above one")

endmodule

// File: dv/tb_pulsing_inverse_square_attractor.sv
// Testbench of the pulsing inverse-square attractor: predicted velocity updates against the block.
`timescale 1ns / 1ps

module tb_pulsing_inverse_square_attractor;

  localparam int TBL_BITS = 10;
  localparam int PIPE_LAT = 77;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [30:0]      mass;
    logic [31:0]      tms;
  } particle_t;

  typedef struct packed {
    logic [2:0][31:0] vel;
    logic             coinc;
    logic             sat;
  } update_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  particle_t   drv = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] new_vel_x_o, new_vel_y_o, new_vel_z_o;
  logic        coincident_o, saturated_o;

  // mirror of the configuration registers
  longint      src_pos [3] = '{0, 0, 0};
  longint      grav_str = 0;
  logic [63:0] src_mass = '0;

  update_t     expected_vel_q[$];
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  int          hold_request = 0;

  pulsing_inverse_square_attractor #(.SINE_TABLE_BITS(TBL_BITS)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .pos_x_i(drv.pos[0]), .pos_y_i(drv.pos[1]), .pos_z_i(drv.pos[2]),
    .vel_x_i(drv.vel[0]), .vel_y_i(drv.vel[1]), .vel_z_i(drv.vel[2]),
    .particle_mass_i(drv.mass), .time_ms_i(drv.tms),
    .out_valid_o, .out_ready_i,
    .new_vel_x_o, .new_vel_y_o, .new_vel_z_o, .coincident_o, .saturated_o
  );

  always #1 clk_i = ~clk_i;

  // Sine table entry in Q1.15 from the truncating odd series
  function automatic longint sine_entry(input logic [63:0] idx);
    logic [63:0] quarter, q, r, a, x, x2, t, v;
    quarter = 64'd1 << (TBL_BITS - 2);
    q = (idx >> (TBL_BITS - 2)) & 64'd3;
    r = idx & (quarter - 64'd1);
    a = q[0] ? quarter - r : r;
    x = (a * pisa_pkg::HALF_PI_Q30) >> (TBL_BITS - 2);
    x2 = (x * x) >> 30;
    t = pisa_pkg::ONE_Q30;
    t = pisa_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t = pisa_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t = pisa_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t = pisa_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t = pisa_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    v = (((x * t) >> 30) + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return q[1] ? -longint'(v) : longint'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Work out the updated velocity of one particle under the current settings
  function automatic update_t predict_velocity(input particle_t p);
    update_t     res;
    longint      vel [3];
    longint      dl, prod, nv;
    logic [63:0] mag [3];
    bit          neg [3];
    bit          gneg, sat;
    logic [63:0] emax, e, frac, idx, gmag, gm, r2, rr, inv, u, dv;
    logic [127:0] x, pr;
    int          bl, sh, n;
    emax = '0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dl = longint'($signed(p.pos[i])) - src_pos[i];
      vel[i] = longint'($signed(p.vel[i]));
      neg[i] = dl < 0;
      mag[i] = neg[i] ? 64'(-dl) : 64'(dl);
      if (mag[i] > emax) emax = mag[i];
    end
    res.coinc = (emax == 0);
    if (!res.coinc && p.mass != 0) begin
      frac = (64'(p.tms) * 64'(pisa_pkg::PHASE_K)) & ((64'd1 << 48) - 64'd1);
      idx = (((frac >> (47 - TBL_BITS)) + 64'd1) >> 1) & ((64'd1 << TBL_BITS) - 64'd1);
      prod = grav_str * sine_entry(idx);
      gneg = prod < 0;
      gmag = ((gneg ? 64'(-prod) : 64'(prod)) + 64'd16384) >> 15;
      gm = gmag * src_mass;
      bl = 0;
      e = emax;
      while (e != 0) begin
        bl++;
        e = e >> 1;
      end
      sh = bl - 30;
      r2 = '0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = (sh >= 0) ? (mag[i] >> sh) : (mag[i] << (-sh));
        r2 = r2 + mag[i] * mag[i];
      end
      rr = int_sqrt(r2);
      inv = 64'h8000_0000_0000_0000 / (r2 >> 28);
      x = 128'(gm) * 128'(inv);
      n = 105 + 2 * sh;
      for (int i = 0; i < 3; i++) begin
        u = (mag[i] << 30) / rr;
        pr = x * 128'(u);
        pr = pr + (128'd1 << (n - 1));
        pr = pr >> n;
        dv = (pr > 128'h100_0000_0000) ? 64'h100_0000_0000 : pr[63:0];
        nv = (neg[i] != gneg) ? vel[i] + longint'(dv) : vel[i] - longint'(dv);
        if (nv > 64'sd2147483647) begin
          nv = 64'sd2147483647;
          sat = 1'b1;
        end
        if (nv < -64'sd2147483648) begin
          nv = -64'sd2147483648;
          sat = 1'b1;
        end
        vel[i] = nv;
      end
    end
    for (int i = 0; i < 3; i++) res.vel[i] = vel[i][31:0];
    res.sat = sat;
    return res;
  endfunction

  // Send one particle, predicting its update at acceptance
  task automatic send_particle(input particle_t p);
    int gap;
    gap = send_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    drv <= p;
    do @(posedge clk_i); while (!in_ready_o);
    expected_vel_q.push_back(predict_velocity(p));
    sent++;
  endtask

  // Drop valid and wait until the pipeline has emptied
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_vel_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pisa_pkg::CFG_SOURCE_X:         src_pos[0] = longint'($signed(val));
      pisa_pkg::CFG_SOURCE_Y:         src_pos[1] = longint'($signed(val));
      pisa_pkg::CFG_SOURCE_Z:         src_pos[2] = longint'($signed(val));
      pisa_pkg::CFG_GRAVITY_STRENGTH: grav_str = longint'($signed(val));
      pisa_pkg::CFG_SOURCE_MASS:      src_mass = 64'(val[30:0]);
      default:                        ;
    endcase
  endtask

  task automatic cfg_all(input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz,
                         input logic [31:0] g, input logic [31:0] m);
    cfg_write(pisa_pkg::CFG_SOURCE_X, sx);
    cfg_write(pisa_pkg::CFG_SOURCE_Y, sy);
    cfg_write(pisa_pkg::CFG_SOURCE_Z, sz);
    cfg_write(pisa_pkg::CFG_GRAVITY_STRENGTH, g);
    cfg_write(pisa_pkg::CFG_SOURCE_MASS, m);
  endtask

  // Random particle: mostly near the source so the pull is felt, some anywhere
  function automatic particle_t rand_particle();
    particle_t p;
    int        span;
    span = $urandom_range(0, 31);
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 3) == 0) p.pos[i] = $urandom;
      else p.pos[i] = 32'(src_pos[i]) + 32'($signed($urandom) >>> span);
      p.vel[i] = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom) >>> 8);
    end
    if ($urandom_range(0, 30) == 0) for (int i = 0; i < 3; i++) p.pos[i] = 32'(src_pos[i]);
    p.mass = ($urandom_range(0, 15) == 0) ? 31'd0 : 31'($urandom);
    p.tms = $urandom;
    return p;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_particle(rand_particle());
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    update_t want;
    logic [31:0] got [3];
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{new_vel_x_o, new_vel_y_o, new_vel_z_o};
      if (expected_vel_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = expected_vel_q.pop_front();
        checked++;
        for (int i = 0; i < 3; i++) begin
          if (got[i] !== want.vel[i]) begin
            $error("new_vel_%0d: expected %h, got %h", i, want.vel[i], got[i]);
            errors++;
          end
        end
        if (coincident_o !== want.coinc) begin
          $error("coincident: expected %b, got %b", want.coinc, coincident_o);
          errors++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls per result, with an occasional long hold-off
  initial begin
    int n;
    wait (rst_ni);
    forever begin
      n = recv_gaps ? $urandom_range(0, 11) : 0;
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Registers at reset: no pull at all
  task automatic test_reset_values;
    send_random(8);
    drain();
  endtask

  // Edges of every field and the special cases
  task automatic test_directed;
    particle_t p;
    cfg_all(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0100_0000, 32'h0100_0000);
    cfg_write(3'd5, 32'hFFFF_FFFF);
    cfg_write(3'd7, 32'h1234_5678);
    // particle on the source, with and without mass
    p = '{pos: {32'h0, 32'hFFFF_0000, 32'h0001_0000}, vel: {32'h7, 32'h8000_0000, 32'h7FFF_FFFF},
          mass: 31'h7FFF_FFFF, tms: 32'd1571};
    send_particle(p);
    p.mass = '0;
    send_particle(p);
    // zero mass away from the source
    p.pos[0] = 32'h0002_0000;
    send_particle(p);
    // extremes of position, velocity and clock
    p = '{pos: {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
          vel: {32'h7FFF_FFFF, 32'h8000_0000, 32'h0},
          mass: 31'h7FFF_FFFF, tms: 32'hFFFF_FFFF};
    send_particle(p);
    p.tms = 32'd0;
    send_particle(p);
    // one unit away, strong pull: saturation both ways
    for (int k = 0; k < 4; k++) begin
      p = '{pos: {32'h0, 32'hFFFF_0000, 32'h0001_0001},
            vel: {32'h0, 32'h0, (k[0] ? 32'h7FFF_FFF0 : 32'h8000_0010)},
            mass: 31'd1, tms: (k[1] ? 32'd4712 : 32'd1571)};
      send_particle(p);
    end
    for (int k = 0; k < 8; k++) begin
      p = rand_particle();
      p.tms = k * 785;
      send_particle(p);
    end
    drain();
    cfg_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    p = '{pos: {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
          vel: {32'h1, 32'hFFFF_FFFF, 32'h0}, mass: 31'd1, tms: 32'd1571};
    send_particle(p);
    p.pos = {32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000};
    send_particle(p);
    send_random(4);
    drain();
  endtask

  // Random particles over several settings, extremes among them
  task automatic test_random_settings;
    cfg_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_random(120);
    drain();
    cfg_all($urandom, $urandom, $urandom, $urandom, 32'h0);
    send_random(60);
    drain();
    cfg_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
    send_random(40);
    drain();
    for (int s = 0; s < 5; s++) begin
      recv_gaps = (s != 2);
      send_gaps = (s != 3);
      cfg_all($urandom, $urandom, $urandom, $urandom >> $urandom_range(0, 24),
              $urandom >> $urandom_range(0, 24));
      send_random(120);
      drain();
    end
    recv_gaps = 1'b1;
    send_gaps = 1'b1;
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure;
    cfg_all($urandom, $urandom, $urandom, $urandom, $urandom);
    send_gaps = 1'b0;
    hold_request = 300;
    send_random(100);
    send_gaps = 1'b1;
    drain();
  endtask

  // Sender pauses mid-stream until every result is back
  task automatic test_sender_pause;
    send_random(40);
    drain();
    send_random(40);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_random_settings();
    test_backpressure();
    test_sender_pause();
    repeat (PIPE_LAT + 20) @(posedge clk_i);
    $display("covered %0d particles, %0d updates checked, over reset, extreme and random settings",
             sent, checked);
    $display("with receiver hold-off, sender pauses and random gaps on both sides");
    if (errors == 0 && expected_vel_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Give up on a hang
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/pisa_pkg.sv
rtl/pulsing_inverse_square_attractor.sv
dv/tb_pulsing_inverse_square_attractor.sv
